// File: sv/clt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_pkg
// Shared types and constants for the closed tour length block.
// ----------------------------------------------------------------------------
package clt_pkg;

    localparam int CRD_W          = 16;           // coordinate field width
    localparam int MAG_W          = 16;           // |difference| of two coordinates
    localparam int PROD_W         = 2 * MAG_W;    // one squared difference
    localparam int SQ_W           = PROD_W + 1;   // dx^2 + dy^2
    localparam int FRAC_BITS      = 8;            // Q.8 result
    localparam int ROOT_W         = 25;           // edge length width
    localparam int RAD_W          = 2 * ROOT_W;   // radicand, sq << 16, padded
    localparam int REM_W          = ROOT_W + 2;   // partial remainder
    localparam int STEP_W         = 5;            // root step counter
    localparam int LEN_W          = 35;
    localparam int CNT_W          = 11;
    localparam int CNT_CAP_MAX    = 2047;
    localparam int OUT_DATA_W     = 48;
    localparam int IN_DATA_W      = 2 * CRD_W;
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_MAX_POINTS = 1024;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_LOAD,
        ST_ROOT,
        ST_ACC,
        ST_EMIT
    } clt_state_t;

    typedef struct packed {
        logic load;        // take the input item
        logic sel_close;   // edge is current -> first
        logic sq_x;
        logic sq_y;
        logic root_start;
        logic acc;
        logic emit;
    } clt_cmd_t;

    typedef struct packed {
        logic have_first;
        logic root_done;
        logic out_free;
    } clt_stat_t;

endpackage

`default_nettype wire

// File: sv/clt_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_sqrt
// Iterative integer square root of (sq << 16), one result bit per cycle.
// ----------------------------------------------------------------------------
module clt_sqrt
    import clt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SQ_W-1:0]   sq,
    output logic                   done,
    output logic [ROOT_W-1:0]      root
);

    logic [RAD_W-1:0]  rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = (REM_W+2)'({root_reg, 2'b01});
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rad_next  = RAD_W'({sq, {(2 * FRAC_BITS){1'b0}}});
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = REM_W'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// File: sv/clt_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_dp
// Datapath: tour state, shared squarer, root unit, length accumulator and
// result register.
// ----------------------------------------------------------------------------
module clt_dp
    import clt_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire clt_cmd_t               cmd,
    output clt_stat_t                   stat,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,
    output logic [OUT_DATA_W-1:0]       m_tdata,
    output logic                        m_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready
);

    localparam int EFF_BITS = (COORD_BITS > CRD_W) ? CRD_W : COORD_BITS;
    localparam int EXT_SH   = CRD_W - EFF_BITS;
    localparam int CAP      = (MAX_POINTS > CNT_CAP_MAX) ? CNT_CAP_MAX : MAX_POINTS;

    logic signed [CRD_W-1:0] in_x_sh, in_y_sh, in_x, in_y;

    logic signed [CRD_W-1:0] cur_x_reg, cur_y_reg;
    logic signed [CRD_W-1:0] prev_x_reg, prev_y_reg;
    logic signed [CRD_W-1:0] first_x_reg, first_y_reg;
    logic                    have_first_reg;
    logic [LEN_W-1:0]        sum_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    sat_reg;
    logic [PROD_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]         sq_reg;
    logic [OUT_DATA_W-1:0]   out_data_reg;
    logic                    out_sat_reg;
    logic                    out_valid_reg;

    logic signed [CRD_W-1:0] op_a, op_b;
    logic signed [CRD_W:0]   diff;
    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [LEN_W:0]          sum_add;
    logic [ROOT_W-1:0]       root;
    logic                    root_done;
    logic                    out_free;

    assign in_x_sh = s_tdata[CRD_W-1:0] << EXT_SH;
    assign in_y_sh = s_tdata[IN_DATA_W-1:CRD_W] << EXT_SH;
    assign in_x    = in_x_sh >>> EXT_SH;
    assign in_y    = in_y_sh >>> EXT_SH;

    // edge endpoints: prev -> cur, or cur -> first on the closing edge
    always_comb
    begin
        if (cmd.sq_y)
        begin
            op_a = cmd.sel_close ? cur_y_reg   : prev_y_reg;
            op_b = cmd.sel_close ? first_y_reg : cur_y_reg;
        end
        else
        begin
            op_a = cmd.sel_close ? cur_x_reg   : prev_x_reg;
            op_b = cmd.sel_close ? first_x_reg : cur_x_reg;
        end
        diff = (CRD_W+1)'(op_a) - (CRD_W+1)'(op_b);
        mag  = diff[CRD_W] ? MAG_W'(-diff) : MAG_W'(diff);
        prod = PROD_W'(mag) * PROD_W'(mag);
    end

    assign sum_add  = (LEN_W+1)'(sum_reg) + (LEN_W+1)'(root);
    assign out_free = !out_valid_reg || m_tready;

    clt_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_start),
        .sq    (sq_reg),
        .done  (root_done),
        .root  (root)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_x_reg <= in_x;
            cur_y_reg <= in_y;
            if (!have_first_reg)
            begin
                first_x_reg <= in_x;
                first_y_reg <= in_y;
                prev_x_reg  <= in_x;
                prev_y_reg  <= in_y;
            end
        end
        if (cmd.acc && !cmd.sel_close)
        begin
            prev_x_reg <= cur_x_reg;
            prev_y_reg <= cur_y_reg;
        end
        if (cmd.sq_x)
            sqx_reg <= prod;
        if (cmd.sq_y)
            sq_reg <= SQ_W'(sqx_reg) + SQ_W'(prod);
        if (cmd.emit)
        begin
            out_data_reg <= OUT_DATA_W'({count_reg, sum_reg});
            out_sat_reg  <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_first_reg <= 1'b0;
            sum_reg        <= '0;
            count_reg      <= '0;
            sat_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                have_first_reg <= 1'b1;
                if (!have_first_reg)
                begin
                    sum_reg   <= '0;
                    count_reg <= CNT_W'(1);
                    sat_reg   <= 1'b0;
                end
                else if (count_reg < CNT_W'(CAP))
                    count_reg <= count_reg + CNT_W'(1);
                else
                    sat_reg <= 1'b1;
            end
            if (cmd.acc)
            begin
                if (sum_add[LEN_W])
                begin
                    sum_reg <= '1;
                    sat_reg <= 1'b1;
                end
                else
                    sum_reg <= sum_add[LEN_W-1:0];
            end
            if (cmd.emit)
            begin
                have_first_reg <= 1'b0;
                sum_reg        <= '0;
                count_reg      <= '0;
                sat_reg        <= 1'b0;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.have_first = have_first_reg;
    assign stat.root_done  = root_done;
    assign stat.out_free   = out_free;

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_sat_reg;
    assign m_tvalid = out_valid_reg;

endmodule

`default_nettype wire

// File: sv/clt_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// clt_ctrl
// Controller: sequences square, root and accumulate steps for each edge.
// ----------------------------------------------------------------------------
module clt_ctrl
    import clt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tlast,
    output logic            s_tready,
    input  wire clt_stat_t  stat,
    output clt_cmd_t        cmd
);

    clt_state_t state_reg, state_next;
    logic       close_reg, close_next;
    logic       last_reg,  last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            close_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            close_reg <= close_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        close_next    = close_reg;
        last_next     = last_reg;
        s_tready      = 1'b0;
        cmd           = '0;
        cmd.sel_close = close_reg;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    last_next  = s_tlast;
                    close_next = !stat.have_first;
                    if (stat.have_first || s_tlast)
                        state_next = ST_SQ_X;
                end
            end
            ST_SQ_X:
            begin
                cmd.sq_x   = 1'b1;
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                cmd.sq_y   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (stat.root_done)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (close_reg)
                    state_next = ST_EMIT;
                else if (last_reg)
                begin
                    close_next = 1'b1;
                    state_next = ST_SQ_X;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/closed_tour_length.sv
`default_nettype none
// ----------------------------------------------------------------------------
// closed_tour_length
// Euclidean length of a closed polygon of integer points, unsigned Q.8.
// ----------------------------------------------------------------------------
// Points arrive one item at a time; tlast marks the last point of a tour,
// after which one result item carries the saturating total length, the
// point count and a saturation flag. Every edge runs through the shared
// squarer (x, then y), the root start, the bit-serial square root (one
// result bit per step), its done flag and one accumulate step. The first
// point of a tour is only stored; the last point runs its own edge and
// then the closing edge before the result load, or only the closing edge
// in a tour of one point. A waiting result sits in the output register
// and does not block the next tour's input.
module closed_tour_length
    import clt_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_DATA_W-1:0]   s_tdata,   // point_x[15:0], point_y[31:16]
    input  wire logic                   s_tlast,   // is_last
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_DATA_W-1:0]       m_tdata,   // tour_length[34:0], point_count[45:35], 0
    output logic                        m_tuser    // saturated
);

    clt_cmd_t  cmd;
    clt_stat_t stat;

    clt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clt_dp #(
        .COORD_BITS (COORD_BITS),
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

`default_nettype wire

// File: sim/closed_tour_length_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// closed_tour_length_checker
// Watches both streams of the closed tour length block, keeps its own model
// of the tour state, predicts every result item and compares it field by
// field with what the block delivers.
// ----------------------------------------------------------------------------
module closed_tour_length_checker
    import clt_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int MAX_POINTS = DEF_MAX_POINTS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // point_x[15:0], point_y[31:16]
    input  logic                   s_tlast,   // is_last
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_DATA_W-1:0]  m_tdata,   // tour_length[34:0], point_count[45:35], 0
    input  logic                   m_tuser,   // saturated
    output int                     fail_count,
    output int                     pending,
    output int                     saturated_seen
);

    localparam int EFF_BITS  = (COORD_BITS > CRD_W) ? CRD_W : COORD_BITS;
    localparam int POINT_CAP = (MAX_POINTS > CNT_CAP_MAX) ? CNT_CAP_MAX : MAX_POINTS;
    localparam logic [63:0] LEN_FULL = (64'd1 << LEN_W) - 64'd1;

    typedef struct packed {
        logic [LEN_W-1:0] tour_length;
        logic [CNT_W-1:0] point_count;
        logic             saturated;
    } tour_result_t;

    tour_result_t            expected_tours[$];
    logic signed [CRD_W-1:0] first_x;
    logic signed [CRD_W-1:0] first_y;
    logic signed [CRD_W-1:0] prev_x;
    logic signed [CRD_W-1:0] prev_y;
    logic                    have_first;
    logic [LEN_W-1:0]        length_sum;
    logic [CNT_W-1:0]        points_seen;
    logic                    sat_flag;

    initial
    begin
        first_x        = '0;
        first_y        = '0;
        prev_x         = '0;
        prev_y         = '0;
        have_first     = 1'b0;
        length_sum     = '0;
        points_seen    = '0;
        sat_flag       = 1'b0;
        fail_count     = 0;
        pending        = 0;
        saturated_seen = 0;
    end

    function automatic logic signed [CRD_W-1:0] to_coord(input logic [CRD_W-1:0] raw);
        logic signed [CRD_W-1:0] v;
        v = raw << (CRD_W - EFF_BITS);
        return v >>> (CRD_W - EFF_BITS);
    endfunction

    function automatic logic [63:0] root_floor(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] probe;
        rem   = n;
        res   = '0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe = probe >> 2;
        while (probe != 0)
        begin
            if (rem >= res + probe)
            begin
                rem = rem - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res = res >> 1;
            probe = probe >> 2;
        end
        return res;
    endfunction

    // floor of the Q.8 distance: sqrt((dx^2 + dy^2) << 16)
    function automatic logic [63:0] edge_q8(input logic signed [CRD_W-1:0] ax,
                                            input logic signed [CRD_W-1:0] ay,
                                            input logic signed [CRD_W-1:0] bx,
                                            input logic signed [CRD_W-1:0] by);
        longint      dx;
        longint      dy;
        logic [63:0] sq;
        dx = longint'(ax) - longint'(bx);
        dy = longint'(ay) - longint'(by);
        if (dx < 0)
            dx = -dx;
        if (dy < 0)
            dy = -dy;
        sq = dx * dx + dy * dy;
        return root_floor(sq << 16);
    endfunction

    function automatic void add_length(input logic [63:0] d);
        logic [63:0] s;
        s = {{(64-LEN_W){1'b0}}, length_sum} + d;
        if (s > LEN_FULL)
        begin
            s        = LEN_FULL;
            sat_flag = 1'b1;
        end
        length_sum = s[LEN_W-1:0];
    endfunction

    function automatic void take_point(input logic [IN_DATA_W-1:0] data, input logic lst);
        logic signed [CRD_W-1:0] x;
        logic signed [CRD_W-1:0] y;
        tour_result_t            r;
        x = to_coord(data[CRD_W-1:0]);
        y = to_coord(data[2*CRD_W-1:CRD_W]);
        if (!have_first)
        begin
            first_x     = x;
            first_y     = y;
            length_sum  = '0;
            points_seen = '0;
            sat_flag    = 1'b0;
        end
        else
            add_length(edge_q8(prev_x, prev_y, x, y));
        prev_x = x;
        prev_y = y;
        if (points_seen < POINT_CAP)
            points_seen = points_seen + 1'b1;
        else
            sat_flag = 1'b1;
        if (!lst)
            have_first = 1'b1;
        else
        begin
            add_length(edge_q8(x, y, first_x, first_y));
            r.tour_length = length_sum;
            r.point_count = points_seen;
            r.saturated   = sat_flag;
            expected_tours = {expected_tours, r};
            have_first  = 1'b0;
            length_sum  = '0;
            points_seen = '0;
            sat_flag    = 1'b0;
        end
    endfunction

    // results are taken before points so a same-edge point cannot be matched early
    always @(posedge clk)
    begin : watch
        tour_result_t got;
        tour_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.tour_length = m_tdata[LEN_W-1:0];
                got.point_count = m_tdata[LEN_W +: CNT_W];
                got.saturated   = m_tuser;
                if (got.saturated === 1'b1)
                    saturated_seen++;
                if (expected_tours.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result item len=%0d cnt=%0d sat=%0b",
                                 $realtime, got.tour_length, got.point_count, got.saturated);
                end
                else
                begin
                    want = expected_tours.pop_front();
                    if (got.tour_length !== want.tour_length
                        || got.point_count !== want.point_count
                        || got.saturated !== want.saturated)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"%0t: result mismatch: expected len=%0d cnt=%0d sat=%0b,",
                                      " got len=%0d cnt=%0d sat=%0b"},
                                     $realtime, want.tour_length, want.point_count,
                                     want.saturated, got.tour_length, got.point_count,
                                     got.saturated);
                    end
                end
            end
            if (s_tvalid && s_tready)
                take_point(s_tdata, s_tlast);
            pending = expected_tours.size();
        end
    end

endmodule

// File: sim/closed_tour_length_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// closed_tour_length_test
// Drives tours of integer points into the closed tour length block: a short
// directed set, random tours of varied shape and size, and one long tour that
// saturates the point count. Both stream sides idle at random; a separate
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
module closed_tour_length_test;
    import clt_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int RANDOM_POINTS = 480;
    localparam int HOLD_CYCLES   = 1500;
    localparam int SETTLE_CYCLES = 100;

    typedef enum int
    {
        PT_ANY,
        PT_NEAR_ORIGIN,
        PT_EXTREME,
        PT_WALK
    } point_style_t;

    localparam logic signed [CRD_W-1:0] C_MIN = 16'sh8000;
    localparam logic signed [CRD_W-1:0] C_MAX = 16'sh7FFF;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;

    int fail_count;
    int pending;
    int saturated_seen;
    int cycles;
    int burst_left;
    int points_sent;
    int tours_sent;
    int holds_done;
    int drains_done;
    bit hold_req;
    bit steady_send;

    closed_tour_length u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    closed_tour_length_checker u_check
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .pending        (pending),
        .saturated_seen (saturated_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
        $display("end of test: mismatches");
        $finish;
    end

    // receiver: random stall patterns drawn from four modes; long hold-off on request
    initial
    begin : rx_side
        int mode;
        int tick;
        int hold_left;
        m_tready  = 1'b0;
        mode      = 0;
        tick      = 0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (tick % 200 == 0)
                mode = $urandom_range(0, 3);
            tick++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 9) > 2);
                    2: m_tready <= ($urandom_range(0, 9) > 7);
                    default: m_tready <= (tick % 4 == 0);
                endcase
        end
    end

    task automatic send_point(input logic signed [CRD_W-1:0] px,
                              input logic signed [CRD_W-1:0] py,
                              input logic lst);
        s_tdata  <= {py, px};
        s_tlast  <= lst;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        points_sent++;
        if (lst)
            tours_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else if (!steady_send)
        begin
            burst_left = $urandom_range(0, 24);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    // sender pause until every result is out, plus a settle time
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        drains_done++;
    endtask

    function automatic logic signed [CRD_W-1:0] pick_coord(input point_style_t style,
                                                           input logic signed [CRD_W-1:0] near);
        case (style)
            PT_ANY:
                return CRD_W'($urandom);
            PT_NEAR_ORIGIN:
                return CRD_W'(int'($urandom_range(0, 127)) - 64);
            PT_EXTREME:
                case ($urandom_range(0, 4))
                    0: return C_MIN;
                    1: return -16'sd1;
                    2: return 16'sd0;
                    3: return 16'sd1;
                    default: return C_MAX;
                endcase
            default:
                return near + CRD_W'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    initial
    begin : stimulus
        point_style_t            style;
        logic signed [CRD_W-1:0] px;
        logic signed [CRD_W-1:0] py;
        int                      base;
        int                      len;
        int                      pick;
        int                      holds_asked;
        bit                      paused;
        bit                      diag;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        hold_req    = 1'b0;
        steady_send = 1'b0;
        burst_left  = 0;
        points_sent = 0;
        tours_sent  = 0;
        holds_done  = 0;
        drains_done = 0;
        holds_asked = 0;
        paused      = 1'b0;
        px          = '0;
        py          = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // single point tour
        send_point(C_MAX, C_MIN, 1'b1);
        // longest possible edge, both ways
        send_point(C_MIN, C_MIN, 1'b0);
        send_point(C_MAX, C_MAX, 1'b1);
        // 3-4-5 triangle
        send_point(16'sd0, 16'sd0, 1'b0);
        send_point(16'sd3, 16'sd0, 1'b0);
        send_point(16'sd3, 16'sd4, 1'b1);
        // repeated point, zero-length edges
        send_point(16'sd5, 16'sd5, 1'b0);
        send_point(16'sd5, 16'sd5, 1'b1);
        send_point(-16'sd1, -16'sd1, 1'b0);
        send_point(16'sd1, 16'sd1, 1'b0);
        send_point(C_MIN, C_MAX, 1'b0);
        send_point(C_MAX, C_MIN, 1'b1);
        send_point(16'sd0, 16'sd0, 1'b1);
        send_point(C_MIN, 16'sd0, 1'b0);
        send_point(C_MAX, 16'sd0, 1'b0);
        send_point(16'sd0, C_MIN, 1'b0);
        send_point(16'sd0, C_MAX, 1'b1);
        wait_drain();

        base = points_sent;
        while (points_sent - base < RANDOM_POINTS)
        begin
            if (holds_asked == 0 && points_sent - base >= 60)
            begin
                hold_req    = 1'b1;
                holds_asked = 1;
            end
            if (!paused && points_sent - base >= 180)
            begin
                wait_drain();
                paused = 1'b1;
            end
            if (holds_asked == 1 && points_sent - base >= 300)
            begin
                hold_req    = 1'b1;
                holds_asked = 2;
            end
            steady_send = (points_sent - base >= 360) && (points_sent - base < 420);

            pick = $urandom_range(0, 19);
            if (pick < 14)
                len = $urandom_range(1, 6);
            else if (pick < 19)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(41, 160);
            style = point_style_t'($urandom_range(0, 3));
            for (int k = 0; k < len; k++)
            begin
                if (k == 0 || $urandom_range(0, 9) != 0)
                begin
                    px = pick_coord(style, px);
                    py = pick_coord(style, py);
                end
                send_point(px, py, k == len - 1);
            end
        end
        steady_send = 1'b0;
        wait_drain();

        // long tour between opposite corners: the point count saturates
        diag = $urandom_range(0, 1);
        len  = $urandom_range(1030, 1060);
        for (int k = 0; k < len; k++)
        begin
            if (k % 2 == 0)
                send_point(C_MIN, diag ? C_MIN : C_MAX, k == len - 1);
            else
                send_point(C_MAX, diag ? C_MAX : C_MIN, k == len - 1);
        end
        wait_drain();

        $display("sent %0d points in %0d tours (%0d results flagged saturated)",
                 points_sent, tours_sent, saturated_seen);
        $display("with %0d receiver hold-offs and %0d full drains of the block",
                 holds_done, drains_done);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
